@@ design/calu8_pkg.sv @@
// ----------------------------------------------------------------------------
// calu8_pkg
// Types, operation codes and constants shared by the 8-bit flag ALU.
// ----------------------------------------------------------------------------
package calu8_pkg;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 16;

  localparam logic [7:0] DaaAdjHi   = 8'h60;
  localparam logic [7:0] DaaAdjLo   = 8'h06;
  localparam logic [7:0] DaaLimitHi = 8'h99;
  localparam logic [3:0] DaaLimitLo = 4'h9;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_ADC  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SBC  = 5'd3,
    OP_AND  = 5'd4,
    OP_XOR  = 5'd5,
    OP_OR   = 5'd6,
    OP_CP   = 5'd7,
    OP_DAA  = 5'd8,
    OP_CPL  = 5'd9,
    OP_SCF  = 5'd10,
    OP_CCF  = 5'd11,
    OP_RLC  = 5'd12,
    OP_RRC  = 5'd13,
    OP_RL   = 5'd14,
    OP_RR   = 5'd15,
    OP_SLA  = 5'd16,
    OP_SRA  = 5'd17,
    OP_SWAP = 5'd18,
    OP_SRL  = 5'd19,
    OP_BIT  = 5'd20,
    OP_RES  = 5'd21,
    OP_SET  = 5'd22,
    OP_RLCA = 5'd23,
    OP_RRCA = 5'd24,
    OP_RLA  = 5'd25,
    OP_RRA  = 5'd26
  } alu_op_e;

  typedef enum logic [2:0] {
    SH_RLC  = 3'd0,
    SH_RRC  = 3'd1,
    SH_RL   = 3'd2,
    SH_RR   = 3'd3,
    SH_SLA  = 3'd4,
    SH_SRA  = 3'd5,
    SH_SWAP = 3'd6,
    SH_SRL  = 3'd7
  } shift_op_e;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [4:0] cmd;
    logic [7:0] acc;
    logic [7:0] operand;
    logic [2:0] bit_pos;
    flags_t     flags;
  } alu_in_t;

  typedef struct packed {
    logic [7:0] result;
    logic       write_result;
    flags_t     flags;
  } alu_out_t;

endpackage

@@ design/calu8_core.sv @@
// ----------------------------------------------------------------------------
// calu8_core
// Combinational datapath: arithmetic, logic, DAA, rotates/shifts and bit ops.
// ----------------------------------------------------------------------------
module calu8_core import calu8_pkg::*; (
  input  alu_in_t  op_i,
  output alu_out_t res_o
);

  function automatic logic [8:0] shift_fn(input shift_op_e k, input logic [7:0] x,
                                          input logic cin);
    logic [8:0] y;
    case (k)
      SH_RLC:  y = {x[7], x[6:0], x[7]};
      SH_RRC:  y = {x[0], x[0], x[7:1]};
      SH_RL:   y = {x[7], x[6:0], cin};
      SH_RR:   y = {x[0], cin, x[7:1]};
      SH_SLA:  y = {x[7], x[6:0], 1'b0};
      SH_SRA:  y = {x[0], x[7], x[7:1]};
      SH_SWAP: y = {1'b0, x[3:0], x[7:4]};
      SH_SRL:  y = {x[0], 1'b0, x[7:1]};
      default: y = '0;
    endcase
    return y;
  endfunction

  alu_op_e    op;
  logic [7:0] a, v;
  logic       cy;
  logic [8:0] sum9, diff9;
  logic [4:0] sum_lo, diff_lo;
  logic       daa_hi, daa_lo;
  logic [7:0] daa_val;
  logic       acc_rot;
  logic [7:0] sh_src;
  logic [4:0] sh_idx;
  logic [8:0] sh_res;
  logic [7:0] bit_mask;
  logic [7:0] r;
  logic       wr;
  flags_t     f;

  assign op = alu_op_e'(op_i.cmd);
  assign a  = op_i.acc;
  assign v  = op_i.operand;
  assign cy = (op == OP_ADC || op == OP_SBC) ? op_i.flags.c : 1'b0;

  assign sum9    = {1'b0, a} + {1'b0, v} + {8'd0, cy};
  assign sum_lo  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cy};
  assign diff9   = {1'b0, a} - {1'b0, v} - {8'd0, cy};
  assign diff_lo = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cy};

  assign daa_hi = op_i.flags.c | (a > DaaLimitHi);
  assign daa_lo = op_i.flags.h | (a[3:0] > DaaLimitLo);

  always_comb begin
    if (!op_i.flags.n) begin
      daa_val = a + (daa_hi ? DaaAdjHi : 8'd0) + (daa_lo ? DaaAdjLo : 8'd0);
    end else begin
      daa_val = a - (op_i.flags.c ? DaaAdjHi : 8'd0) - (op_i.flags.h ? DaaAdjLo : 8'd0);
    end
  end

  assign acc_rot  = op inside {[OP_RLCA:OP_RRA]};
  assign sh_src   = acc_rot ? a : v;
  assign sh_idx   = acc_rot ? (op_i.cmd - OP_RLCA) : (op_i.cmd - OP_RLC);
  assign sh_res   = shift_fn(shift_op_e'(sh_idx[2:0]), sh_src, op_i.flags.c);
  assign bit_mask = 8'd1 << op_i.bit_pos;

  always_comb begin
    r  = 8'd0;
    wr = 1'b1;
    f  = op_i.flags;
    case (op)
      OP_ADD, OP_ADC: begin
        r = sum9[7:0];
        f = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: sum_lo[4], c: sum9[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        r  = diff9[7:0];
        wr = (op != OP_CP);
        f  = '{z: (diff9[7:0] == 8'd0), n: 1'b1, h: diff_lo[4], c: diff9[8]};
      end
      OP_AND: begin
        r = a & v;
        f = '{z: ((a & v) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      OP_XOR: begin
        r = a ^ v;
        f = '{z: ((a ^ v) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_OR: begin
        r = a | v;
        f = '{z: ((a | v) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_DAA: begin
        r   = daa_val;
        f.z = (daa_val == 8'd0);
        f.h = 1'b0;
        if (!op_i.flags.n) begin
          f.c = daa_hi;
        end
      end
      OP_CPL: begin
        r   = ~a;
        f.n = 1'b1;
        f.h = 1'b1;
      end
      OP_SCF: begin
        wr = 1'b0;
        f  = '{z: op_i.flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      OP_CCF: begin
        wr = 1'b0;
        f  = '{z: op_i.flags.z, n: 1'b0, h: 1'b0, c: ~op_i.flags.c};
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL,
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        r = sh_res[7:0];
        f = '{z: (!acc_rot && sh_res[7:0] == 8'd0), n: 1'b0, h: 1'b0, c: sh_res[8]};
      end
      OP_BIT: begin
        wr = 1'b0;
        f  = '{z: ~v[op_i.bit_pos], n: 1'b0, h: 1'b1, c: op_i.flags.c};
      end
      OP_RES: r = v & ~bit_mask;
      OP_SET: r = v | bit_mask;
      default: wr = 1'b0;
    endcase
  end

  assign res_o.result       = wr ? r : 8'd0;
  assign res_o.write_result = wr;
  assign res_o.flags        = f;

endmodule

@@ design/cpu_alu_8bit_flags.sv @@
// ----------------------------------------------------------------------------
// cpu_alu_8bit_flags
// 8-bit ALU with Z/N/H/C flags behind an input register and a result register.
// An accepted input passes the input register, then the result register, to the output.
// Throughput: 1 item per cycle; both stages advance whenever the result
// register is empty or being taken.
// Reset: asynchronous, active low; clears both stage valid flags.
// ----------------------------------------------------------------------------
module cpu_alu_8bit_flags import calu8_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [4:0] cmd, [12:5] acc, [20:13] operand, [23:21] bit_pos,
  // [24] z_in, [25] n_in, [26] h_in, [27] c_in, [31:28] zero
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [7:0] result, [8] write_result, [9] z_out, [10] n_out, [11] h_out,
  // [12] c_out, [15:13] zero
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  alu_in_t  in_d, in_q;
  logic     in_vld_q;
  alu_out_t out_d, out_q;
  logic     out_vld_q;
  logic     out_load, in_load;

  assign out_load        = !out_vld_q || m_axis_tready_i;
  assign in_load         = !in_vld_q || out_load;
  assign s_axis_tready_o = in_load;

  assign in_d.cmd     = s_axis_tdata_i[4:0];
  assign in_d.acc     = s_axis_tdata_i[12:5];
  assign in_d.operand = s_axis_tdata_i[20:13];
  assign in_d.bit_pos = s_axis_tdata_i[23:21];
  assign in_d.flags   = '{z: s_axis_tdata_i[24], n: s_axis_tdata_i[25],
                          h: s_axis_tdata_i[26], c: s_axis_tdata_i[27]};

  calu8_core u_core (
    .op_i  (in_q),
    .res_o (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (out_load) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && s_axis_tvalid_i) begin
      in_q <= in_d;
    end
    if (out_load && in_vld_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'b000, out_q.flags.c, out_q.flags.h, out_q.flags.n,
                            out_q.flags.z, out_q.write_result, out_q.result};

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for cpu_alu_8bit_flags. Directed items hit flag edge
// cases for every command, then random items run under several handshake
// idle/stall mixes. A scoreboard predicts each result and checks items in
// order.
// ----------------------------------------------------------------------------
module tb import calu8_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 460;
  localparam int unsigned HoldCycles = 300;

  class alu_flag_scoreboard;
    logic [15:0] pending_results[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    function logic [15:0] predict_alu(logic [31:0] item);
      logic [4:0] cmd;
      logic [7:0] a, v, r, x;
      logic [2:0] pos, sh;
      logic       z, n, h, c, wr, cy;
      logic [8:0] t;
      logic [4:0] lo;
      cmd = item[4:0];
      a   = item[12:5];
      v   = item[20:13];
      pos = item[23:21];
      z   = item[24];
      n   = item[25];
      h   = item[26];
      c   = item[27];
      r   = 8'h00;
      wr  = 1'b1;
      case (cmd)
        OP_ADD, OP_ADC: begin
          cy = (cmd == OP_ADC) ? c : 1'b0;
          t  = {1'b0, a} + {1'b0, v} + {8'h00, cy};
          lo = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'h0, cy};
          h  = lo[4];
          c  = t[8];
          r  = t[7:0];
          n  = 1'b0;
          z  = (r == 8'h00);
        end
        OP_SUB, OP_SBC, OP_CP: begin
          cy = (cmd == OP_SBC) ? c : 1'b0;
          t  = {1'b0, a} - {1'b0, v} - {8'h00, cy};
          lo = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'h0, cy};
          h  = lo[4];
          c  = t[8];
          n  = 1'b1;
          z  = (t[7:0] == 8'h00);
          if (cmd == OP_CP) begin
            wr = 1'b0;
          end else begin
            r = t[7:0];
          end
        end
        OP_AND: begin
          r = a & v; z = (r == 8'h00); n = 1'b0; h = 1'b1; c = 1'b0;
        end
        OP_XOR: begin
          r = a ^ v; z = (r == 8'h00); n = 1'b0; h = 1'b0; c = 1'b0;
        end
        OP_OR: begin
          r = a | v; z = (r == 8'h00); n = 1'b0; h = 1'b0; c = 1'b0;
        end
        OP_DAA: begin
          t = {1'b0, a};
          if (!n) begin
            if (c || a > DaaLimitHi) begin
              t = t + {1'b0, DaaAdjHi};
              c = 1'b1;
            end
            if (h || a[3:0] > DaaLimitLo) t = t + {1'b0, DaaAdjLo};
          end else begin
            if (c) t = t - {1'b0, DaaAdjHi};
            if (h) t = t - {1'b0, DaaAdjLo};
          end
          r = t[7:0];
          z = (r == 8'h00);
          h = 1'b0;
        end
        OP_CPL: begin
          r = ~a; n = 1'b1; h = 1'b1;
        end
        OP_SCF: begin
          wr = 1'b0; n = 1'b0; h = 1'b0; c = 1'b1;
        end
        OP_CCF: begin
          wr = 1'b0; n = 1'b0; h = 1'b0; c = ~c;
        end
        OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL,
        OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
          x  = (cmd >= OP_RLCA) ? a : v;
          sh = (cmd >= OP_RLCA) ? 3'(cmd - OP_RLCA) : 3'(cmd - OP_RLC);
          case (sh)
            SH_RLC:  begin r = {x[6:0], x[7]}; c = x[7]; end
            SH_RRC:  begin r = {x[0], x[7:1]}; c = x[0]; end
            SH_RL:   begin r = {x[6:0], c};    c = x[7]; end
            SH_RR:   begin r = {c, x[7:1]};    c = x[0]; end
            SH_SLA:  begin r = {x[6:0], 1'b0}; c = x[7]; end
            SH_SRA:  begin r = {x[7], x[7:1]}; c = x[0]; end
            SH_SWAP: begin r = {x[3:0], x[7:4]}; c = 1'b0; end
            default: begin r = {1'b0, x[7:1]}; c = x[0]; end
          endcase
          n = 1'b0;
          h = 1'b0;
          z = (cmd >= OP_RLCA) ? 1'b0 : (r == 8'h00);
        end
        OP_BIT: begin
          wr = 1'b0; z = ~v[pos]; n = 1'b0; h = 1'b1;
        end
        OP_RES: r = v & ~(8'h01 << pos);
        OP_SET: r = v | (8'h01 << pos);
        default: wr = 1'b0;
      endcase
      if (!wr) r = 8'h00;
      return {3'b000, c, h, n, z, wr, r};
    endfunction

    function void note_item(logic [31:0] item);
      pending_results.push_back(predict_alu(item));
    endfunction

    function void compare_field(string fname, logic [7:0] exp_v, logic [7:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, got_v);
      end
    endfunction

    function void check_result(logic [15:0] got);
      logic [15:0] exp_r;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none, actual %0h", $time, got);
        return;
      end
      exp_r = pending_results.pop_front();
      checked++;
      compare_field("result", exp_r[7:0], got[7:0]);
      compare_field("write_result", 8'(exp_r[8]), 8'(got[8]));
      compare_field("z_out", 8'(exp_r[9]), 8'(got[9]));
      compare_field("n_out", 8'(exp_r[10]), 8'(got[10]));
      compare_field("h_out", 8'(exp_r[11]), 8'(got[11]));
      compare_field("c_out", 8'(exp_r[12]), 8'(got[12]));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;

  alu_flag_scoreboard sb;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned items_sent;
  int unsigned cycle_cnt;
  bit          hold_req;

  cpu_alu_8bit_flags i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
  end

  // receiver ready; long hold-offs are counted here
  initial begin
    int unsigned hold_left;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        hold_left = HoldCycles;
        while (hold_left > 0) begin
          @(posedge clk_i);
          hold_left--;
        end
        hold_req = 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic logic [31:0] pack_item(logic [4:0] cmd, logic [7:0] acc,
                                            logic [7:0] opd, logic [2:0] pos,
                                            logic z, logic n, logic h, logic c);
    return {4'h0, c, h, n, z, pos, opd, acc, cmd};
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] corner[10] = '{8'h00, 8'h01, 8'h0F, 8'h10, 8'h7F,
                              8'h80, 8'h99, 8'h9A, 8'hF0, 8'hFF};
    if ($urandom_range(3) == 0) return corner[$urandom_range(9)];
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [31:0] random_item();
    logic [4:0] cmd;
    logic [3:0] fl;
    if ($urandom_range(9) == 0) cmd = 5'($urandom_range(31, 27));
    else cmd = 5'($urandom_range(26));
    fl = 4'($urandom_range(15));
    return pack_item(cmd, pick_byte(), pick_byte(), 3'($urandom_range(7)),
                     fl[0], fl[1], fl[2], fl[3]);
  endfunction

  task automatic send_item(logic [31:0] item);
    s_axis_tdata_i  <= item;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_item(item);
    items_sent++;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  initial begin
    logic [31:0] directed[$];
    int unsigned tx_mix[4];
    int unsigned rx_mix[4];
    tx_mix          = '{0, 60, 0, 18};
    rx_mix          = '{0, 0, 60, 18};
    sb              = new();
    cycle_cnt       = 0;
    items_sent      = 0;
    hold_req        = 1'b0;
    tx_idle_pct     = 0;
    rx_stall_pct    = 0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{
      pack_item(OP_ADD,  8'hFF, 8'h01, 3'd0, 0, 1, 0, 0),
      pack_item(OP_ADC,  8'h0F, 8'h00, 3'd0, 0, 0, 0, 1),
      pack_item(OP_ADC,  8'hFF, 8'hFF, 3'd0, 1, 1, 1, 1),
      pack_item(OP_SUB,  8'h3C, 8'h3C, 3'd0, 0, 0, 1, 1),
      pack_item(OP_SBC,  8'h00, 8'h00, 3'd0, 0, 0, 0, 1),
      pack_item(OP_AND,  8'hF0, 8'h0F, 3'd0, 0, 1, 0, 1),
      pack_item(OP_XOR,  8'hFF, 8'h00, 3'd0, 1, 1, 1, 1),
      pack_item(OP_OR,   8'h00, 8'h00, 3'd0, 0, 1, 1, 1),
      pack_item(OP_CP,   8'h10, 8'h20, 3'd0, 0, 0, 0, 0),
      pack_item(OP_DAA,  8'h9A, 8'h00, 3'd0, 0, 0, 0, 0),
      pack_item(OP_DAA,  8'h45, 8'h00, 3'd0, 0, 0, 1, 0),
      pack_item(OP_DAA,  8'h66, 8'h00, 3'd0, 0, 1, 1, 1),
      pack_item(OP_CPL,  8'h5A, 8'h00, 3'd0, 1, 0, 0, 1),
      pack_item(OP_SCF,  8'h12, 8'h34, 3'd0, 1, 1, 1, 0),
      pack_item(OP_CCF,  8'h00, 8'h00, 3'd0, 0, 1, 1, 1),
      pack_item(OP_RLC,  8'h00, 8'h80, 3'd0, 0, 1, 1, 0),
      pack_item(OP_RRC,  8'h00, 8'h01, 3'd0, 0, 0, 0, 0),
      pack_item(OP_RL,   8'h00, 8'h80, 3'd0, 0, 0, 0, 0),
      pack_item(OP_RR,   8'h00, 8'h00, 3'd0, 1, 0, 0, 1),
      pack_item(OP_SLA,  8'h00, 8'h80, 3'd0, 0, 0, 0, 0),
      pack_item(OP_SRA,  8'h00, 8'h81, 3'd0, 0, 0, 0, 0),
      pack_item(OP_SWAP, 8'h00, 8'hF0, 3'd0, 0, 0, 0, 1),
      pack_item(OP_SRL,  8'h00, 8'h01, 3'd0, 0, 0, 0, 0),
      pack_item(OP_BIT,  8'h00, 8'h80, 3'd7, 1, 1, 0, 1),
      pack_item(OP_BIT,  8'h00, 8'hFE, 3'd0, 0, 1, 0, 0),
      pack_item(OP_RES,  8'h00, 8'hFF, 3'd7, 1, 1, 1, 1),
      pack_item(OP_SET,  8'h00, 8'h00, 3'd0, 0, 0, 0, 0),
      pack_item(OP_RLCA, 8'h80, 8'h00, 3'd0, 1, 1, 1, 0),
      pack_item(OP_RRCA, 8'h00, 8'h00, 3'd0, 1, 0, 0, 0),
      pack_item(OP_RLA,  8'hFF, 8'h00, 3'd0, 0, 0, 0, 1),
      pack_item(OP_RRA,  8'h01, 8'h00, 3'd0, 0, 0, 0, 0),
      pack_item(5'd27,   8'hFF, 8'hFF, 3'd7, 1, 1, 1, 1),
      pack_item(5'd31,   8'h00, 8'h00, 3'd0, 0, 0, 0, 0)
    };
    foreach (directed[i]) send_item(directed[i]);

    for (int p = 0; p < 4; p++) begin
      tx_idle_pct  = tx_mix[p];
      rx_stall_pct = rx_mix[p];
      // first phase: sink stalls for a long stretch so the pipe backs up
      if (p == 0) hold_req = 1'b1;
      for (int k = 0; k < PhaseItems; k++) send_item(random_item());
    end
    s_axis_tvalid_i <= 1'b0;
    rx_stall_pct = 0;

    while (sb.pending_results.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d items (directed corners, all 32 command codes, random flags)",
             items_sent);
    $display("under 4 idle/stall mixes plus one long sink hold-off; %0d results checked",
             sb.checked);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
